// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands shared by the residual statistics RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on a given clock, muted while the given reset is low.
`define ABRS_ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the module's clk_i / rst_ni pair.
`define ABRS_ASSERT(label, prop, msg) \
  `ABRS_ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

// ===== src/abrs_pkg.sv =====
// ----------------------------------------------------------------------------
// abrs_pkg
// Types, widths and codes shared by the residual statistics block.
// ----------------------------------------------------------------------------
package abrs_pkg;

  localparam int unsigned BIN_COUNT_DEF = 4096;

  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 248;
  localparam int unsigned CODE_W      = 2;

  // bin width codes
  localparam logic [CODE_W-1:0] STEP_WHOLE     = 2'd0;
  localparam logic [CODE_W-1:0] STEP_TENTH     = 2'd1;
  localparam logic [CODE_W-1:0] STEP_HUNDREDTH = 2'd2;

  // item kinds
  localparam logic FUNC_ACC = 1'b0;
  localparam logic FUNC_REP = 1'b1;

  // angle to bin mapping: reciprocals for divide by 100 and by 10
  localparam logic [17:0] ANGLE_OFFSET = 18'd18000;
  localparam logic [16:0] RECIP_100    = 17'd83887;
  localparam int unsigned RECIP_100_SH = 23;
  localparam logic [16:0] RECIP_10     = 17'd52429;
  localparam int unsigned RECIP_10_SH  = 19;
  localparam logic [16:0] HALF_100     = 17'd50;
  localparam logic [16:0] HALF_10      = 17'd5;

  localparam logic [63:0] PCT_SCALE = 64'd10000;
  localparam logic [63:0] PCT_MAX   = 64'd1000000;

  typedef struct packed {
    logic        [23:0] neg_cnt;
    logic        [23:0] pos_cnt;
    logic signed [49:0] rsum;
    logic        [63:0] qsum;
    logic signed [48:0] dsum;
    logic signed [24:0] dmin;
    logic signed [24:0] dmax;
    logic        [25:0] amax;
  } bin_row_t;

  localparam bin_row_t ROW_RESET = '{
    neg_cnt: '0, pos_cnt: '0, rsum: '0, qsum: '0, dsum: '0,
    dmin: 25'h0FFFFFF, dmax: 25'h1000000, amax: '0
  };

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } unit_op_e;

  typedef enum logic [3:0] {
    RS_MR, RS_NQ, RS_SS, RS_NN, RS_VAR, RS_SD, RS_QN, RS_RMS,
    RS_MD, RS_SP, RS_PCT, RS_NP, RS_NEG, RS_PP, RS_POS
  } rep_step_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_INDEX, ST_READ, ST_ACC_CALC, ST_ACC_WRITE,
    ST_REP_LOAD, ST_OP_START, ST_OP_WAIT, ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic      in_take;
    logic      calc_index;
    logic      mem_rd;
    logic      acc_calc;
    logic      acc_wr;
    logic      clear_wr;
    logic      rep_load;
    logic      op_start;
    logic      out_load;
    rep_step_e step;
  } dp_cmd_t;

  typedef struct packed {
    logic is_report;
    logic skip;
    logic trivial;
    logic unit_done;
    logic clear_last;
    logic out_free;
  } dp_status_t;

  function automatic unit_op_e step_op(rep_step_e s);
    unit_op_e op;
    case (s)
      RS_NQ, RS_SS, RS_NN, RS_SP, RS_NP, RS_PP: op = OP_MUL;
      RS_SD, RS_RMS:                            op = OP_SQRT;
      default:                                  op = OP_DIV;
    endcase
    return op;
  endfunction

endpackage

// ===== src/angle_binned_residual_stats.sv =====
// Accumulate: each input transfer passes the index, read, square and write steps; a skipped one ends after the read.
// Report: paced by the shared bit-serial unit (seven 128-step divides,
//   six 64-step multiplies, two 32-step roots); a bin with fewer than two samples or
//   a select beyond the store skips the unit. One item in flight at a time.
// Reset: asynchronous, active low; a clearing pass then writes every bin, during
//   which no input transfer is taken.
// ----------------------------------------------------------------------------
// angle_binned_residual_stats
// Per-angle-bin residual statistics with a registered result stage.
// ----------------------------------------------------------------------------
module angle_binned_residual_stats #(
  parameter int unsigned BIN_COUNT = abrs_pkg::BIN_COUNT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // steer_angle, sounding_depth, reference_depth, sample_ok, bin_select, zero pad
  input  logic [abrs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // func
  input  logic                                s_axis_tuser,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // sample_count, mean_residual, residual_stddev, residual_rms, stddev_pct_depth,
  // negative_pct, positive_pct, max_abs_residual, mean_depth, lowest_depth,
  // highest_depth
  output logic [abrs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // stats_valid
  output logic                                m_axis_tuser,
  // bin width register
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [abrs_pkg::CODE_W-1:0]         cfg_data_i
);
  import abrs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // the register takes every transfer; writes must only arrive while idle, which the block itself does not enforce
  assign cfg_ready_o = 1'b1;

  // sequencer: clear pass, accumulate and report steps
  abrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // store, arithmetic and output register
  abrs_dp #(
    .BIN_COUNT (BIN_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata),
    .in_func_i   (s_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

// ===== src/abrs_unit.sv =====
// ----------------------------------------------------------------------------
// abrs_unit
// Bit-serial multiply, restoring divide and integer square root.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module abrs_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  abrs_pkg::unit_op_e  op_i,
  input  logic [127:0]        a_i,
  input  logic [63:0]         b_i,
  output logic                done_o,
  output logic [127:0]        result_o
);
  import abrs_pkg::*;

  logic         busy_q, busy_d, done_q, done_d;
  unit_op_e     op_q, op_d;
  logic [6:0]   cnt_q, cnt_d, last;
  logic [127:0] sh_q, sh_d, acc_q, acc_d;
  logic [63:0]  dv_q, dv_d;
  logic [64:0]  r_div;
  logic [65:0]  r_sq, trial;

  always_comb begin
    case (op_q)
      OP_MUL:  last = 7'd63;
      OP_SQRT: last = 7'd31;
      default: last = 7'd127;
    endcase
  end

  assign r_div = {acc_q[63:0], sh_q[127]};
  assign r_sq  = {acc_q[63:0], sh_q[127:126]};
  assign trial = {dv_q, 2'b01};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    acc_d  = acc_q;
    dv_d   = dv_q;
    if (start_i) begin
      busy_d = 1'b1;
      op_d   = op_i;
      cnt_d  = '0;
      acc_d  = '0;
      case (op_i)
        OP_MUL: begin
          sh_d = {64'd0, a_i[63:0]};
          dv_d = b_i;
        end
        OP_SQRT: begin
          sh_d = {a_i[63:0], 64'd0};
          dv_d = '0;
        end
        default: begin
          sh_d = a_i;
          dv_d = b_i;
        end
      endcase
    end else if (busy_q) begin
      case (op_q)
        OP_MUL: begin
          if (dv_q[0]) acc_d = acc_q + sh_q;
          sh_d = {sh_q[126:0], 1'b0};
          dv_d = {1'b0, dv_q[63:1]};
        end
        OP_SQRT: begin
          sh_d = {sh_q[125:0], 2'b00};
          if (r_sq >= trial) begin
            acc_d = {62'd0, r_sq - trial};
            dv_d  = {dv_q[62:0], 1'b1};
          end else begin
            acc_d = {62'd0, r_sq};
            dv_d  = {dv_q[62:0], 1'b0};
          end
        end
        default: begin
          if (r_div >= {1'b0, dv_q}) begin
            acc_d = {63'd0, r_div - {1'b0, dv_q}};
            sh_d  = {sh_q[126:0], 1'b1};
          end else begin
            acc_d = {63'd0, r_div};
            sh_d  = {sh_q[126:0], 1'b0};
          end
        end
      endcase
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    acc_q <= acc_d;
    dv_q  <= dv_d;
  end

  always_comb begin
    case (op_q)
      OP_MUL:  result_o = acc_q;
      OP_SQRT: result_o = {64'd0, dv_q};
      default: result_o = (sh_q[127:64] != 64'd0) ? {64'd0, {64{1'b1}}}
                                                 : {64'd0, sh_q[63:0]};
    endcase
  end

  assign done_o = done_q;

  `ABRS_ASSERT(a_no_restart, start_i |-> !busy_q, "unit started while busy")

endmodule

// ===== src/abrs_dp.sv =====
// ----------------------------------------------------------------------------
// abrs_dp
// Bin store, accumulate update, report arithmetic and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module abrs_dp #(
  parameter int unsigned BIN_COUNT = abrs_pkg::BIN_COUNT_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  abrs_pkg::dp_cmd_t                    cmd_i,
  output abrs_pkg::dp_status_t                 status_o,
  input  logic [abrs_pkg::IN_TDATA_W-1:0]      in_data_i,
  input  logic                                 in_func_i,
  input  logic                                 cfg_valid_i,
  input  logic [abrs_pkg::CODE_W-1:0]          cfg_data_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic [abrs_pkg::OUT_TDATA_W-1:0]     out_data_o,
  output logic                                 out_user_o
);
  import abrs_pkg::*;

  localparam int unsigned AW = $clog2(BIN_COUNT);

  // configuration
  logic [CODE_W-1:0] code_q;

  // captured item
  logic               func_q, ok_q;
  logic signed [15:0] ang_q;
  logic signed [24:0] dep_q, ref_q;
  logic [11:0]        sel_q;

  // bin index
  logic signed [17:0] v;
  logic               v_neg, idx_skip, sel_oor;
  logic [16:0]        y, rin, rk;
  logic [33:0]        rprod;
  logic [15:0]        mag, sel16;
  logic [AW-1:0]      addr_q;
  logic               skip_q, oor_q;

  // store
  bin_row_t mem [BIN_COUNT];
  bin_row_t rdata_q, wr_row, new_row;
  logic [AW-1:0] clr_cnt_q, wr_addr;
  logic          wr_en;

  // accumulate
  logic signed [25:0] diff, diff_q;
  logic [24:0]        absd, absd_q;
  logic [49:0]        sq_q;
  logic [49:0]        dsum_x;
  logic [50:0]        rsum_x;
  logic [64:0]        qsum_x;

  // report
  logic [24:0]        n_comb, n_q, half_n;
  logic               s_neg_q, d_neg_q, stat_ok_q;
  logic [49:0]        s_abs_q;
  logic [48:0]        d_abs_q;
  logic [127:0]       nq_q, ss_q, op_a, res;
  logic [63:0]        op_b, dd_q, tmp_q, q64;
  logic [25:0]        mr_q;
  logic [24:0]        sd_q, rms_q, md_q, md_abs_q;
  logic [19:0]        pct_q;
  logic [13:0]        neg_pct_q, pos_pct_q;
  logic               unit_done;

  // output
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_q, out_d;
  logic                   out_user_q;
  logic [23:0]            cnt_out;
  logic [24:0]            amax_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= '0;
    end else if (cfg_valid_i) begin
      code_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take) begin
      func_q <= in_func_i;
      ang_q  <= in_data_i[15:0];
      dep_q  <= in_data_i[40:16];
      ref_q  <= in_data_i[65:41];
      ok_q   <= in_data_i[66];
      sel_q  <= in_data_i[78:67];
    end
  end

  // v = 18000 - angle, then round |v| / 100 (whole) or |v| / 10 (tenth) half away from zero; hundredth keeps |v|
  always_comb begin
    v     = $signed(ANGLE_OFFSET) - $signed({{2{ang_q[15]}}, ang_q});
    v_neg = v[17];
    y     = v_neg ? 17'(-v) : v[16:0];
    case (code_q)
      STEP_WHOLE: begin
        rin = y + HALF_100;
        rk  = RECIP_100;
      end
      STEP_TENTH: begin
        rin = y + HALF_10;
        rk  = RECIP_10;
      end
      default: begin
        rin = y;
        rk  = '0;
      end
    endcase
    rprod = rin * rk;
    case (code_q)
      STEP_WHOLE: mag = 16'(rprod >> RECIP_100_SH);
      STEP_TENTH: mag = 16'(rprod >> RECIP_10_SH);
      default:    mag = y[15:0];
    endcase
    sel16    = 16'(sel_q);
    sel_oor  = {5'd0, sel_q} >= 17'(BIN_COUNT);
    idx_skip = !ok_q || (dep_q == '0) || (ref_q == '0) || (v_neg && (mag != '0)) ||
               ({1'b0, mag} >= 17'(BIN_COUNT));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_index) begin
      addr_q <= (func_q == FUNC_REP) ? sel16[AW-1:0] : mag[AW-1:0];
      skip_q <= idx_skip;
      oor_q  <= sel_oor;
    end
  end

  // clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear_wr) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  assign wr_en   = cmd_i.clear_wr || cmd_i.acc_wr;
  assign wr_addr = cmd_i.clear_wr ? clr_cnt_q : addr_q;
  assign wr_row  = cmd_i.clear_wr ? ROW_RESET : new_row;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_row;
    if (cmd_i.mem_rd) rdata_q <= mem[addr_q];
  end

  // accumulate: residual and its square
  always_comb begin
    diff = $signed({ref_q[24], ref_q}) - $signed({dep_q[24], dep_q});
    absd = diff[25] ? 25'(-diff) : diff[24:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_calc) begin
      diff_q <= diff;
      absd_q <= absd;
      sq_q   <= absd * absd;
    end
  end

  always_comb begin
    new_row = rdata_q;
    if (dep_q < rdata_q.dmin) new_row.dmin = dep_q;
    if (dep_q > rdata_q.dmax) new_row.dmax = dep_q;
    dsum_x = {rdata_q.dsum[48], rdata_q.dsum} + {{25{dep_q[24]}}, dep_q};
    if (dsum_x[49] != dsum_x[48]) begin
      new_row.dsum = dsum_x[49] ? {1'b1, 48'd0} : {1'b0, {48{1'b1}}};
    end else begin
      new_row.dsum = dsum_x[48:0];
    end
    rsum_x = {rdata_q.rsum[49], rdata_q.rsum} + {{25{diff_q[25]}}, diff_q};
    if (rsum_x[50] != rsum_x[49]) begin
      new_row.rsum = rsum_x[50] ? {1'b1, 49'd0} : {1'b0, {49{1'b1}}};
    end else begin
      new_row.rsum = rsum_x[49:0];
    end
    qsum_x = {1'b0, rdata_q.qsum} + {15'd0, sq_q};
    new_row.qsum = qsum_x[64] ? {64{1'b1}} : qsum_x[63:0];
    if (diff_q[25]) begin
      if (!(&rdata_q.neg_cnt)) new_row.neg_cnt = rdata_q.neg_cnt + 24'd1;
    end else begin
      if (!(&rdata_q.pos_cnt)) new_row.pos_cnt = rdata_q.pos_cnt + 24'd1;
    end
    if ({1'b0, absd_q} > rdata_q.amax) new_row.amax = {1'b0, absd_q};
  end

  // report: snapshot of the bin
  assign n_comb = {1'b0, rdata_q.neg_cnt} + {1'b0, rdata_q.pos_cnt};
  assign half_n = {1'b0, n_q[24:1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.rep_load) begin
      n_q       <= oor_q ? '0 : n_comb;
      stat_ok_q <= !(oor_q || (n_comb <= 25'd1));
      s_neg_q   <= rdata_q.rsum[49];
      s_abs_q   <= rdata_q.rsum[49] ? 50'(-rdata_q.rsum) : rdata_q.rsum;
      d_neg_q   <= rdata_q.dsum[48];
      d_abs_q   <= rdata_q.dsum[48] ? 49'(-rdata_q.dsum) : rdata_q.dsum;
    end
  end

  always_comb begin
    op_a = '0;
    op_b = 64'(n_q);
    case (cmd_i.step)
      RS_MR:  op_a = 128'(s_abs_q + 50'(half_n));
      RS_NQ:  op_a = 128'(rdata_q.qsum);
      RS_SS: begin
        op_a = 128'(s_abs_q);
        op_b = 64'(s_abs_q);
      end
      RS_NN: begin
        op_a = 128'(n_q);
        op_b = 64'(n_q - 25'd1);
      end
      RS_VAR: begin
        op_a = (nq_q > ss_q) ? (nq_q - ss_q) : '0;
        op_b = dd_q;
      end
      RS_SD, RS_RMS: op_a = 128'(tmp_q);
      RS_QN:  op_a = 128'(rdata_q.qsum);
      RS_MD:  op_a = 128'(d_abs_q + 49'(half_n));
      RS_SP: begin
        op_a = 128'(sd_q);
        op_b = PCT_SCALE;
      end
      RS_PCT: begin
        op_a = 128'(tmp_q);
        op_b = 64'(md_abs_q);
      end
      RS_NP: begin
        op_a = 128'(rdata_q.neg_cnt);
        op_b = PCT_SCALE;
      end
      RS_PP: begin
        op_a = 128'(rdata_q.pos_cnt);
        op_b = PCT_SCALE;
      end
      RS_NEG, RS_POS: op_a = 128'(tmp_q);
      default: op_a = '0;
    endcase
  end

  abrs_unit u_unit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.op_start),
    .op_i     (step_op(cmd_i.step)),
    .a_i      (op_a),
    .b_i      (op_b),
    .done_o   (unit_done),
    .result_o (res)
  );

  assign q64 = res[63:0];

  always_ff @(posedge clk_i) begin
    if (unit_done) begin
      case (cmd_i.step)
        RS_MR:  mr_q <= s_neg_q ? 26'(64'd0 - q64) : q64[25:0];
        RS_NQ:  nq_q <= res;
        RS_SS:  ss_q <= res;
        RS_NN:  dd_q <= q64;
        RS_SD:  sd_q <= (q64 > 64'h1FFFFFF) ? {25{1'b1}} : q64[24:0];
        RS_RMS: rms_q <= (q64 > 64'h1FFFFFF) ? {25{1'b1}} : q64[24:0];
        RS_MD: begin
          if (d_neg_q) begin
            if (q64 > 64'd16777216) begin
              md_q     <= 25'h1000000;
              md_abs_q <= 25'h1000000;
            end else begin
              md_q     <= 25'(64'd0 - q64);
              md_abs_q <= q64[24:0];
            end
          end else begin
            if (q64 > 64'd16777215) begin
              md_q     <= 25'h0FFFFFF;
              md_abs_q <= 25'h0FFFFFF;
            end else begin
              md_q     <= q64[24:0];
              md_abs_q <= q64[24:0];
            end
          end
        end
        RS_PCT: begin
          if (md_abs_q == '0) pct_q <= '0;
          else pct_q <= (q64 > PCT_MAX) ? PCT_MAX[19:0] : q64[19:0];
        end
        RS_NEG: neg_pct_q <= q64[13:0];
        RS_POS: pos_pct_q <= q64[13:0];
        default: tmp_q <= q64;
      endcase
    end
  end

  // result assembly
  always_comb begin
    cnt_out  = n_q[24] ? {24{1'b1}} : n_q[23:0];
    amax_out = rdata_q.amax[25] ? {25{1'b1}} : rdata_q.amax[24:0];
    if (stat_ok_q) begin
      out_d = {rdata_q.dmax, rdata_q.dmin, md_q, amax_out, pos_pct_q, neg_pct_q,
               pct_q, rms_q, sd_q, mr_q, cnt_out};
    end else begin
      out_d = {224'd0, cnt_out};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q      <= out_d;
      out_user_q <= stat_ok_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_user_o  = out_user_q;

  assign status_o.is_report  = (func_q == FUNC_REP);
  assign status_o.skip       = skip_q;
  assign status_o.trivial    = oor_q || (n_comb <= 25'd1);
  assign status_o.unit_done  = unit_done;
  assign status_o.clear_last = (clr_cnt_q == AW'(BIN_COUNT - 1));
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  `ABRS_ASSERT(a_wr_after_calc, cmd_i.acc_wr |-> $past(cmd_i.acc_calc), "bin write without update calc")
  `ABRS_ASSERT(a_load_free, cmd_i.out_load |-> (!out_valid_q || out_ready_i), "result overwritten")

endmodule

// ===== src/abrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// abrs_ctrl
// Sequencer for clearing, accumulate read-modify-write and report steps.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module abrs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  abrs_pkg::dp_status_t  status_i,
  output abrs_pkg::dp_cmd_t     cmd_o
);
  import abrs_pkg::*;

  ctrl_state_e state_q, state_d;
  rep_step_e   step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      step_q  <= RS_MR;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_CLEAR:     if (status_i.clear_last) state_d = ST_IDLE;
      ST_IDLE:      if (in_valid_i) state_d = ST_INDEX;
      ST_INDEX:     state_d = ST_READ;
      ST_READ: begin
        if (status_i.is_report) state_d = ST_REP_LOAD;
        else if (status_i.skip) state_d = ST_IDLE;
        else state_d = ST_ACC_CALC;
      end
      ST_ACC_CALC:  state_d = ST_ACC_WRITE;
      ST_ACC_WRITE: state_d = ST_IDLE;
      ST_REP_LOAD: begin
        step_d  = RS_MR;
        state_d = status_i.trivial ? ST_OUT : ST_OP_START;
      end
      ST_OP_START:  state_d = ST_OP_WAIT;
      ST_OP_WAIT: begin
        if (status_i.unit_done) begin
          if (step_q == RS_POS) begin
            state_d = ST_OUT;
          end else begin
            step_d  = rep_step_e'(step_q + 4'd1);
            state_d = ST_OP_START;
          end
        end
      end
      ST_OUT:       if (status_i.out_free) state_d = ST_IDLE;
      default:      state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready_o       = (state_q == ST_IDLE);
    cmd_o.in_take    = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.calc_index = (state_q == ST_INDEX);
    cmd_o.mem_rd     = (state_q == ST_READ);
    cmd_o.acc_calc   = (state_q == ST_ACC_CALC);
    cmd_o.acc_wr     = (state_q == ST_ACC_WRITE);
    cmd_o.clear_wr   = (state_q == ST_CLEAR);
    cmd_o.rep_load   = (state_q == ST_REP_LOAD);
    cmd_o.op_start   = (state_q == ST_OP_START);
    cmd_o.out_load   = (state_q == ST_OUT) && status_i.out_free;
    cmd_o.step       = step_q;
  end

  `ABRS_ASSERT(a_start_wait, cmd_o.op_start |=> (state_q == ST_OP_WAIT), "no wait after start")
  `ABRS_ASSERT(a_done_in_wait, status_i.unit_done |-> (state_q == ST_OP_WAIT), "stray unit done")

endmodule
